/* sv/hte_pkg.sv */
// hte_pkg: shared types and constants of the table-driven Huffman encoder.
// Used by the front end, the command queue, the bit packer and the top level.
// No dependencies.
package hte_pkg;

    // Fixed field widths of the item format.
    localparam int SYM_W       = 8;
    localparam int LEN_W       = 5;
    localparam int CODE_W      = 31;
    localparam int OP_W        = 2;
    localparam int BYTE_W      = 8;
    localparam int IN_DATA_W   = 48;

    // Bit positions of the fields inside s_tdata.
    localparam int SYM_LSB     = 0;
    localparam int LEN_LSB     = SYM_LSB + SYM_W;
    localparam int CODE_LSB    = LEN_LSB + LEN_W;

    // Bits that can wait in the packer for a byte to complete.
    localparam int PEND_W      = BYTE_W - 1;

    // Command queue between the front end and the packer.
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 2);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        CMD_ENC   = 2'd0,
        CMD_FLUSH = 2'd1,
        CMD_ERR   = 2'd2
    } cmd_kind_t;

    // One packer command: an encode carries its looked-up code.
    typedef struct packed {
        cmd_kind_t          kind;
        logic [CODE_W-1:0]  code;
        logic [LEN_W-1:0]   len;
    } cmd_t;

endpackage

/* sv/hte_front.sv */
// hte_front: accepts input items, writes the code table and looks up symbols.
// Hands packer commands to the queue in the cycle after acceptance.
// Depends on hte_pkg.
module hte_front import hte_pkg::*; #(
    parameter int ALPHABET_SIZE = 256,
    parameter int MAX_CODE_LEN  = 31
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic [OP_W-1:0]      s_tuser,
    input  logic [CNT_W-1:0]     fifo_count,
    output logic                 push,
    output cmd_t                 push_cmd
);

    localparam int IDX_W = $clog2(ALPHABET_SIZE);

    logic [MAX_CODE_LEN-1:0] code_mem [ALPHABET_SIZE];
    logic [LEN_W-1:0]        len_mem  [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] entry_valid_reg;

    logic                    lkp_valid_reg;
    cmd_kind_t               lkp_kind_reg;
    logic                    lkp_err_reg;
    logic [MAX_CODE_LEN-1:0] rd_code_reg;
    logic [LEN_W-1:0]        rd_len_reg;

    logic [SYM_W-1:0]  symbol;
    logic [LEN_W-1:0]  code_length;
    logic [CODE_W-1:0] code_bits;
    logic [IDX_W-1:0]  idx;
    logic              in_range;
    logic              accept;
    logic [LEN_W-1:0]  len_sat;
    logic [CODE_W-1:0] code_masked;

    assign symbol      = s_tdata[SYM_LSB +: SYM_W];
    assign code_length = s_tdata[LEN_LSB +: LEN_W];
    assign code_bits   = s_tdata[CODE_LSB +: CODE_W];
    assign idx         = symbol[IDX_W-1:0];
    assign in_range    = ({1'b0, symbol} < (SYM_W+1)'(ALPHABET_SIZE));
    assign accept      = s_tvalid && s_tready;

    assign len_sat     = (code_length > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
                                                              : code_length;
    assign code_masked = code_bits & ~({CODE_W{1'b1}} << len_sat);

    // Room is reserved for the item in the lookup stage as well.
    assign s_tready = (fifo_count + CNT_W'(lkp_valid_reg)) < CNT_W'(QUEUE_DEPTH);

    // Table memory: one write or one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (accept && s_tuser == OP_LOAD && in_range) begin
            code_mem[idx] <= MAX_CODE_LEN'(code_masked);
            len_mem[idx]  <= len_sat;
        end
        if (accept && s_tuser == OP_ENCODE) begin
            rd_code_reg <= code_mem[idx];
            rd_len_reg  <= len_mem[idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
            lkp_valid_reg   <= 1'b0;
            lkp_kind_reg    <= CMD_FLUSH;
            lkp_err_reg     <= 1'b0;
        end else begin
            lkp_valid_reg <= 1'b0;
            if (accept) begin
                case (s_tuser)
                    OP_LOAD: begin
                        if (in_range) begin
                            entry_valid_reg[idx] <= 1'b1;
                        end
                    end
                    OP_ENCODE: begin
                        lkp_valid_reg <= 1'b1;
                        lkp_kind_reg  <= CMD_ENC;
                        lkp_err_reg   <= !(in_range && entry_valid_reg[idx]);
                    end
                    OP_FLUSH: begin
                        lkp_valid_reg <= 1'b1;
                        lkp_kind_reg  <= CMD_FLUSH;
                        lkp_err_reg   <= 1'b0;
                    end
                    default: begin
                        lkp_valid_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    // A zero-length code appends nothing, so it never reaches the packer.
    always_comb begin
        push_cmd.kind = lkp_err_reg ? CMD_ERR : lkp_kind_reg;
        push_cmd.code = CODE_W'(rd_code_reg);
        push_cmd.len  = rd_len_reg;
        push = lkp_valid_reg &&
               !(lkp_kind_reg == CMD_ENC && !lkp_err_reg && rd_len_reg == '0);
    end

endmodule

/* sv/hte_cmd_fifo.sv */
// hte_cmd_fifo: short command queue between the front end and the packer.
// Register-based, one push and one pop per cycle.
// Depends on hte_pkg.
module hte_cmd_fifo import hte_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  cmd_t             push_cmd,
    input  logic             pop,
    output logic             head_valid,
    output cmd_t             head_cmd,
    output logic [CNT_W-1:0] count
);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |-> count_reg < CNT_W'(QUEUE_DEPTH))
        else $error("command queue overflow");

endmodule

/* sv/hte_packer.sv */
// hte_packer: bit packer that carries out queued commands and drives results.
// Emits one byte per cycle into a registered output stage when m_ is not stalled.
// Depends on hte_pkg.
module hte_packer import hte_pkg::*; #(
    parameter int MAX_CODE_LEN = 31
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  cmd_t              head_cmd,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,
    output logic              m_tuser,
    output logic              m_tlast
);

    localparam int ACC_W = MAX_CODE_LEN + PEND_W;
    localparam int TOT_W = $clog2(ACC_W + 1);

    // Only the low total_reg bits of acc_reg are meaningful; bits above are
    // never read, so they need no clearing.
    logic [ACC_W-1:0]  acc_reg,   acc_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] data_reg,  data_next;
    logic              err_reg,   err_next;
    logic              last_reg,  last_next;

    logic              out_free;
    logic [TOT_W-1:0]  emit_sh;
    logic [2:0]        flush_sh;

    assign out_free = !valid_reg || m_tready;
    assign emit_sh  = total_reg - TOT_W'(BYTE_W);
    assign flush_sh = 3'(4'd8 - 4'(total_reg));

    always_comb begin
        acc_next   = acc_reg;
        total_next = total_reg;
        valid_next = valid_reg && !m_tready;
        data_next  = data_reg;
        err_next   = err_reg;
        last_next  = last_reg;
        pop        = 1'b0;

        if (total_reg >= TOT_W'(BYTE_W)) begin
            if (out_free) begin
                valid_next = 1'b1;
                data_next  = BYTE_W'(acc_reg >> emit_sh);
                err_next   = 1'b0;
                last_next  = (emit_sh < TOT_W'(BYTE_W));
                total_next = emit_sh;
            end
        end else if (head_valid) begin
            case (head_cmd.kind)
                CMD_ENC: begin
                    pop        = 1'b1;
                    acc_next   = (acc_reg << head_cmd.len) | ACC_W'(head_cmd.code);
                    total_next = total_reg + TOT_W'(head_cmd.len);
                end
                CMD_FLUSH: begin
                    if (total_reg == '0) begin
                        pop = 1'b1;
                    end else if (out_free) begin
                        pop        = 1'b1;
                        valid_next = 1'b1;
                        data_next  = acc_reg[BYTE_W-1:0] << flush_sh;
                        err_next   = 1'b0;
                        last_next  = 1'b1;
                        total_next = '0;
                    end
                end
                CMD_ERR: begin
                    if (out_free) begin
                        pop        = 1'b1;
                        valid_next = 1'b1;
                        data_next  = '0;
                        err_next   = 1'b1;
                        last_next  = 1'b1;
                    end
                end
                default: begin
                    pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        data_reg <= data_next;
        err_reg  <= err_next;
        last_reg <= last_next;
        if (!aresetn) begin
            total_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            total_reg <= total_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = err_reg;
    assign m_tlast  = last_reg;

    a_pop_needs_head: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("packer popped an empty queue");

    a_total_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= TOT_W'(ACC_W))
        else $error("packer bit count out of range");

    a_err_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && m_tdata == '0)
        else $error("error result must be a single zero byte");

    a_busy_no_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg >= TOT_W'(BYTE_W) |-> !pop)
        else $error("command taken while a byte is still pending");

endmodule

/* sv/huffman_table_encoder.sv */
// huffman_table_encoder: top level of the table-driven Huffman byte encoder.
// Instantiates hte_front, hte_cmd_fifo and hte_packer; depends on hte_pkg.
//
//  Channel  Direction  Handshake           Contents
//  s_       in         s_tvalid/s_tready   tuser: opcode; tdata: symbol,
//                                          code_length, code_bits
//  m_       out        m_tvalid/m_tready   tdata: out_byte; tuser:
//                                          unknown_symbol; tlast: last
//
// The front end takes one item per cycle while the command queue has room.
// Loads finish at acceptance; encodes and flushes reach the queue in the
// following cycle, after the registered table read.
// The packer takes an encode command and then emits each completed byte
// before it takes the next command; this packer loop sets the sustained
// rate.
// Reset clears the table's valid bits, the queue and the packer at once, so
// no clearing pass is needed. A stall on m_ holds the output register and
// backs up through the queue to s_tready; the table content is kept.
module huffman_table_encoder import hte_pkg::*; #(
    parameter int ALPHABET_SIZE = 256,
    parameter int MAX_CODE_LEN  = 31
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input items.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,  // symbol[7:0], code_length[12:8],
                                           // code_bits[43:13], zeros[47:44]
    input  logic [OP_W-1:0]      s_tuser,  // opcode[1:0]
    // Result items.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [BYTE_W-1:0]    m_tdata,  // out_byte[7:0]
    output logic                 m_tuser,  // unknown_symbol[0]
    output logic                 m_tlast
);

    logic             push;
    cmd_t             push_cmd;
    logic             pop;
    logic             head_valid;
    cmd_t             head_cmd;
    logic [CNT_W-1:0] fifo_count;

    // Front end: table writes and symbol lookup.
    hte_front #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .MAX_CODE_LEN  (MAX_CODE_LEN)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .fifo_count (fifo_count),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // Queue that lets the front end run ahead of the packer.
    hte_cmd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .count      (fifo_count)
    );

    // Back end: bit packing and result delivery.
    hte_packer #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_packer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
